// ----- design/rdh_pkg.sv -----
// Shared constants and widths for the radial distance histogram.
`timescale 1ns / 1ps

package rdh_pkg;

  // Histogram storage: the bin index is exactly BIN_W bits wide.
  localparam int BIN_W    = 7;
  localparam int MAX_BINS = 1 << BIN_W;

  // Number of spatial dimensions; z is ignored when this is 2.
  localparam int DIMS = 3;

  localparam int COUNT_W = 32;
  localparam int RAD_W   = 31;
  localparam int NB_W    = 8;
  localparam int POS_W   = 32;

  // Packed beat widths.
  localparam int IN_W  = 1 + POS_W + POS_W + BIN_W;      // 72 bits, already whole bytes
  localparam int OUT_W = 1 + BIN_W + COUNT_W;            // 40 bits

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(9830);
  localparam logic [NB_W-1:0]  BINS_RESET   = NB_W'(100);

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // Input opcodes, carried in tuser.
  typedef enum logic {
    OP_BIN  = 1'b0,
    OP_READ = 1'b1
  } opcode_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_RADIUS   = 2'd0,
    REG_BINS     = 2'd1,
    REG_CENTER_Y = 2'd2,
    REG_CENTER_Z = 2'd3
  } cfg_reg_t;

endpackage

// ----- design/radial_distance_histogram.sv -----
// Top level of the radial distance histogram: sequencer, shared units and bin memory.
`timescale 1ns / 1ps

//  Channel   Direction  Beat contents (low bit first)
//  s_*       in         tuser: opcode; tdata: movable, pos_y, pos_z, read_bin
//  m_*       out        tdata: hit, bin_index, bin_count
//  cfg_*     in         cfg_index selects radius, bins_in_use, center_y, center_z
//
//  A counted sample raises m_tvalid after the offset, range check and squaring states, 31 square
//  root steps, 1 scaling product, 8 division steps, the bin read-modify-write and the beat load.
//  A read passes only the bin read and update states before the beat load; a sample that is not
//  counted goes on to the beat load as soon as that is known.
//  Reset (rst, synchronous) clears the sequencer, the output beat and every bin valid bit.
//  s_tready is high only in idle; a stalled beat holds, and the next result then blocks input.

module radial_distance_histogram (
  input  logic                       clk,
  input  logic                       rst,
  // Input beat. tuser: [0] opcode.
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [0:0]                 s_tuser,
  // tdata: [0] movable, [32:1] pos_y, [64:33] pos_z, [71:65] read_bin.
  input  logic [rdh_pkg::IN_W-1:0]   s_tdata,
  // Result beat. tdata: [0] hit, [7:1] bin_index, [39:8] bin_count.
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rdh_pkg::OUT_W-1:0]  m_tdata,
  // Configuration write channel.
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);

  localparam int BIN_W   = rdh_pkg::BIN_W;
  localparam int COUNT_W = rdh_pkg::COUNT_W;
  localparam int RAD_W   = rdh_pkg::RAD_W;
  localparam int NB_W    = rdh_pkg::NB_W;
  localparam int POS_W   = rdh_pkg::POS_W;
  localparam int OFF_W   = POS_W + 1;
  localparam int QDIG    = 8;   // quotient digits; quotient stays below 256
  localparam int SQ_STEPS = RAD_W;

  typedef enum logic [3:0] {
    S_IDLE, S_OFFY, S_OFFZ, S_CHKY, S_CHKZ, S_MULY, S_MULZ, S_MULR,
    S_CHKD, S_SQRT, S_MULS, S_DIV, S_MEMRD, S_MEMUPD, S_EMIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [RAD_W-1:0]  radius;
  logic [NB_W-1:0]   bins_in_use;
  logic [POS_W-1:0]  center_y;
  logic [POS_W-1:0]  center_z;

  // Captured item.
  logic              is_read;
  logic [POS_W-1:0]  pos_y;
  logic [POS_W-1:0]  pos_z;

  // Working registers.
  logic [OFF_W-1:0]  off_y;
  logic [OFF_W-1:0]  off_z;
  logic [63:0]       prod;
  logic [63:0]       acc;
  logic [63:0]       rem;
  logic [63:0]       sq_res;
  logic [63:0]       sq_bit;
  logic [4:0]        step;
  logic [QDIG-1:0]   quot;
  logic [BIN_W-1:0]  bin;

  // Result waiting for the output register.
  logic              res_hit;
  logic [COUNT_W-1:0] res_count;

  // Bin memory with one valid bit per entry; an entry never written reads as zero.
  logic [COUNT_W-1:0]          mem [rdh_pkg::MAX_BINS];
  logic [COUNT_W-1:0]          rd_data;
  logic [rdh_pkg::MAX_BINS-1:0] bin_valid;

  // Shared add/subtract unit. With alu_sub set, the carry out means alu_a >= alu_b.
  logic [63:0] alu_a;
  logic [63:0] alu_b;
  logic        alu_sub;
  logic [64:0] alu_sum;
  logic        alu_ge;

  // Shared multiplier.
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_p;

  logic [NB_W-1:0]    nb;
  logic [OFF_W-1:0]   off_raw;
  logic [OFF_W-1:0]   off_abs;
  logic [QDIG-1:0]    quot_next;
  logic [COUNT_W-1:0] cur_count;
  logic [COUNT_W-1:0] new_count;
  logic               in_fire;

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = s_tvalid && s_tready;

  // Effective bin count: zero acts as one, anything above the table size is clamped.
  always_comb begin
    if (bins_in_use == '0) begin
      nb = NB_W'(1);
    end else if (bins_in_use > NB_W'(rdh_pkg::MAX_BINS)) begin
      nb = NB_W'(rdh_pkg::MAX_BINS);
    end else begin
      nb = bins_in_use;
    end
  end

  // Operand selection for the shared units.
  always_comb begin
    alu_a   = rem;
    alu_b   = '0;
    alu_sub = 1'b1;
    mul_a   = off_y[31:0];
    mul_b   = off_y[31:0];
    case (state)
      S_OFFY: begin
        alu_a = 64'(signed'(pos_y));
        alu_b = 64'(signed'(center_y));
      end
      S_OFFZ: begin
        alu_a = 64'(signed'(pos_z));
        alu_b = 64'(signed'(center_z));
      end
      S_CHKY: begin
        alu_a = 64'(off_y);
        alu_b = 64'(radius);
      end
      S_CHKZ: begin
        alu_a = 64'(off_z);
        alu_b = 64'(radius);
      end
      S_MULY: begin
        mul_a = off_y[31:0];
        mul_b = off_y[31:0];
      end
      S_MULZ: begin
        mul_a = off_z[31:0];
        mul_b = off_z[31:0];
      end
      S_MULR: begin
        alu_a   = acc;
        alu_b   = prod;
        alu_sub = 1'b0;
        mul_a   = 32'(radius);
        mul_b   = 32'(radius);
      end
      S_CHKD: begin
        alu_a = rem;
        alu_b = prod;
      end
      S_SQRT: begin
        alu_a = rem;
        alu_b = sq_res | sq_bit;
      end
      S_MULS: begin
        mul_a = sq_res[31:0];
        mul_b = 32'(nb);
      end
      S_DIV: begin
        alu_a = rem;
        alu_b = 64'(radius) << step[2:0];
      end
      default: begin
        alu_a = rem;
      end
    endcase
  end

  assign alu_sum = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + 65'(alu_sub);
  assign alu_ge  = alu_sum[64];
  assign mul_p   = 64'(mul_a) * 64'(mul_b);

  // The offset fits in 33 bits signed; take its magnitude.
  assign off_raw = alu_sum[OFF_W-1:0];
  assign off_abs = off_raw[OFF_W-1] ? (~off_raw + OFF_W'(1)) : off_raw;

  always_comb begin
    quot_next = quot;
    quot_next[step[2:0]] = alu_ge;
  end

  // Saturating increment of the addressed bin.
  assign cur_count = bin_valid[bin] ? rd_data : '0;
  assign new_count = (cur_count == rdh_pkg::COUNT_MAX) ? cur_count : cur_count + COUNT_W'(1);

  // Bin memory port: one registered read and one write per cycle at the same address.
  always_ff @(posedge clk) begin
    rd_data <= mem[bin];
    if (state == S_MEMUPD && !is_read) begin
      mem[bin] <= new_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      bin_valid   <= '0;
      radius      <= rdh_pkg::RADIUS_RESET;
      bins_in_use <= rdh_pkg::BINS_RESET;
      center_y    <= '0;
      center_z    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rdh_pkg::REG_RADIUS:   radius      <= cfg_data[RAD_W-1:0];
          rdh_pkg::REG_BINS:     bins_in_use <= cfg_data[NB_W-1:0];
          rdh_pkg::REG_CENTER_Y: center_y    <= cfg_data;
          rdh_pkg::REG_CENTER_Z: center_z    <= cfg_data;
          default:               radius      <= radius;
        endcase
      end

      // The emit state loads the next beat itself when it takes the output register.
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_fire) begin
            is_read   <= (s_tuser[0] != rdh_pkg::OP_BIN);
            pos_y     <= s_tdata[32:1];
            pos_z     <= s_tdata[64:33];
            // A sample reports bin zero unless it is counted.
            bin       <= (s_tuser[0] != rdh_pkg::OP_BIN) ? s_tdata[71:65] : '0;
            res_hit   <= 1'b0;
            res_count <= '0;
            if (s_tuser[0] != rdh_pkg::OP_BIN) begin
              state <= S_MEMRD;
            end else if (!s_tdata[0] || radius == '0) begin
              state <= S_EMIT;
            end else begin
              state <= S_OFFY;
            end
          end
        end
        S_OFFY: begin
          off_y <= off_abs;
          state <= S_OFFZ;
        end
        S_OFFZ: begin
          if (rdh_pkg::DIMS >= 3) begin
            off_z <= off_abs;
          end else begin
            off_z <= '0;
          end
          state <= S_CHKY;
        end
        S_CHKY: begin
          state <= alu_ge ? S_EMIT : S_CHKZ;
        end
        S_CHKZ: begin
          state <= alu_ge ? S_EMIT : S_MULY;
        end
        S_MULY: begin
          prod  <= mul_p;
          state <= S_MULZ;
        end
        S_MULZ: begin
          acc   <= prod;
          prod  <= mul_p;
          state <= S_MULR;
        end
        S_MULR: begin
          // Squared distance into the remainder; radius squared into the product.
          rem   <= alu_sum[63:0];
          prod  <= mul_p;
          state <= S_CHKD;
        end
        S_CHKD: begin
          sq_res <= '0;
          sq_bit <= 64'd1 << (2 * (SQ_STEPS - 1));
          step   <= 5'(SQ_STEPS - 1);
          state  <= alu_ge ? S_EMIT : S_SQRT;
        end
        S_SQRT: begin
          // One result bit per cycle of the digit-by-digit square root.
          if (alu_ge) begin
            rem    <= alu_sum[63:0];
            sq_res <= (sq_res >> 1) | sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          step   <= step - 5'd1;
          if (step == '0) begin
            state <= S_MULS;
          end
        end
        S_MULS: begin
          rem   <= mul_p;
          quot  <= '0;
          step  <= 5'(QDIG - 1);
          state <= S_DIV;
        end
        S_DIV: begin
          // Restoring division by the radius, most significant quotient bit first.
          if (alu_ge) begin
            rem <= alu_sum[63:0];
          end
          quot <= quot_next;
          step <= step - 5'd1;
          if (step[2:0] == '0) begin
            bin   <= quot_next[BIN_W-1:0];
            state <= S_MEMRD;
          end
        end
        S_MEMRD: begin
          if (!is_read && quot >= nb) begin
            bin   <= '0;
            state <= S_EMIT;
          end else begin
            state <= S_MEMUPD;
          end
        end
        S_MEMUPD: begin
          if (is_read) begin
            res_count <= cur_count;
          end else begin
            res_hit        <= 1'b1;
            res_count      <= new_count;
            bin_valid[bin] <= 1'b1;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {res_count, bin, res_hit};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/rdh_checker.sv -----
// Port-level checks for the radial distance histogram and their binding.
`timescale 1ns / 1ps

module rdh_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_tvalid,
  input logic                      s_tready,
  input logic                      m_tvalid,
  input logic                      m_tready,
  input logic [rdh_pkg::OUT_W-1:0] m_tdata,
  input logic                      cfg_ready
);

  // The block works on one item at a time.
  assert property (@(posedge clk) disable iff (rst) (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken while an item is in progress");

  // A counted sample always leaves a nonzero count in its bin.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[0]) |-> (m_tdata[rdh_pkg::OUT_W-1:rdh_pkg::BIN_W+1] != '0))
    else $error("hit reported with a zero count");

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("result beat changed while stalled");

  // Reset empties the output register.
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // Configuration writes are never stalled.
  assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration port not ready");

endmodule

bind radial_distance_histogram rdh_checker u_rdh_checker (.*);
